@@ rtl/svpl_pkg.sv @@
// Shared types, constants and saturating helpers for the segmented V-plane intersection block.
package svpl_pkg;

    localparam int QW   = 48;
    localparam int FRAC = 16;
    localparam int HW   = QW / 2;

    typedef logic signed [QW-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

    // Number of plane segments, clamped to the three that have registers.
    localparam int SEGMENTS = 3;
    localparam int NSEG     = (SEGMENTS > 3) ? 3 : ((SEGMENTS < 1) ? 1 : SEGMENTS);
    localparam int SEG_W    = 2;

    localparam int DIV_STEPS = QW + FRAC;
    localparam int MUL_LAT   = 4;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOPE_X  = 3'd0,
        REG_SLOPE_Z0 = 3'd1,
        REG_SLOPE_Z1 = 3'd2,
        REG_SLOPE_Z2 = 3'd3,
        REG_OFFSET0  = 3'd4,
        REG_Z_LIMIT0 = 3'd5,
        REG_Z_LIMIT1 = 3'd6,
        REG_Z_LIMIT2 = 3'd7
    } cfg_reg_t;

    localparam q_t Z_LIMIT0_RST = 48'sd26214400;
    localparam q_t Z_LIMIT1_RST = 48'sd72089600;
    localparam q_t Z_LIMIT2_RST = 48'sd65536000000;

    typedef struct packed {
        q_t   px;
        q_t   py;
        q_t   pz;
        logic dzero;
    } trk_t;

    typedef struct packed {
        q_t bx;
        q_t by;
    } dir_t;

    typedef struct packed {
        q_t               z;
        logic [SEG_W-1:0] seg;
        logic             wing;
        logic             err;
    } sel_t;

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s[QW] != s[QW-1])
            return s[QW] ? Q_MIN : Q_MAX;
        return s[QW-1:0];
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} - {b[QW-1], b};
        if (s[QW] != s[QW-1])
            return s[QW] ? Q_MIN : Q_MAX;
        return s[QW-1:0];
    endfunction

    function automatic logic [QW-1:0] mag(input q_t v);
        return v[QW-1] ? QW'(-v) : QW'(v);
    endfunction

    // Applies a sign to an unsigned magnitude and clips to the signed range.
    function automatic q_t sat_mag(input logic [QW-1:0] m, input logic neg);
        if (neg)
            return m[QW-1] ? Q_MIN : q_t'(-m);
        return m[QW-1] ? Q_MAX : q_t'(m);
    endfunction

endpackage

@@ rtl/svpl_mul.sv @@
// Four-stage rounding, saturating Q31.16 multiplier built from 24x24 partial products.
module svpl_mul (
    input  logic          clk,
    input  logic          en,
    input  svpl_pkg::q_t  a,
    input  svpl_pkg::q_t  b,
    output svpl_pkg::q_t  p
);
    import svpl_pkg::*;

    localparam int PW = 2 * QW + 1;

    logic [QW-1:0]   ma_reg, mb_reg;
    logic            neg1_reg, neg2_reg, neg3_reg;
    logic [2*HW-1:0] p11_reg, p10_reg, p01_reg, p00_reg;
    logic [PW-1:0]   rnd_reg, rnd_next;
    q_t              p_reg, p_next;

    always_comb
    begin
        rnd_next = (PW'(p11_reg) << QW) + ((PW'(p10_reg) + PW'(p01_reg)) << HW)
                 + PW'(p00_reg) + (PW'(1) << (FRAC - 1));
    end

    always_comb
    begin
        if (rnd_reg[PW-1:QW+FRAC] != '0)
            p_next = neg3_reg ? Q_MIN : Q_MAX;
        else
            p_next = sat_mag(rnd_reg[QW+FRAC-1:FRAC], neg3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= mag(a);
            mb_reg   <= mag(b);
            neg1_reg <= a[QW-1] ^ b[QW-1];
            p11_reg  <= ma_reg[QW-1:HW] * mb_reg[QW-1:HW];
            p10_reg  <= ma_reg[QW-1:HW] * mb_reg[HW-1:0];
            p01_reg  <= ma_reg[HW-1:0] * mb_reg[QW-1:HW];
            p00_reg  <= ma_reg[HW-1:0] * mb_reg[HW-1:0];
            neg2_reg <= neg1_reg;
            rnd_reg  <= rnd_next;
            neg3_reg <= neg2_reg;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/svpl_div.sv @@
// Pipelined restoring divider for Q31.16 with round-to-nearest and saturation.
module svpl_div (
    input  logic          clk,
    input  logic          en,
    input  svpl_pkg::q_t  a,
    input  svpl_pkg::q_t  b,
    output svpl_pkg::q_t  q
);
    import svpl_pkg::*;

    // Stage zero holds the prepared operands; each later stage retires one quotient bit.
    logic [DIV_STEPS-1:0] nq_reg  [DIV_STEPS+1];
    logic [QW-1:0]        rem_reg [DIV_STEPS+1];
    logic [QW-1:0]        d_reg   [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];
    logic [QW-1:0]        mb;
    logic [DIV_STEPS-1:0] num;
    q_t                   q_reg, q_next;

    always_comb
    begin
        mb  = mag(b);
        num = {mag(a), FRAC'(0)} + DIV_STEPS'(mb >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]  <= num;
            rem_reg[0] <= '0;
            d_reg[0]   <= mb;
            neg_reg[0] <= a[QW-1] ^ b[QW-1];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        logic [QW:0] r2;
        logic        take;

        always_comb
        begin
            r2   = {rem_reg[j], nq_reg[j][DIV_STEPS-1]};
            take = (r2 >= {1'b0, d_reg[j]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= take ? QW'(r2 - {1'b0, d_reg[j]}) : r2[QW-1:0];
                nq_reg[j+1]  <= {nq_reg[j][DIV_STEPS-2:0], take};
                d_reg[j+1]   <= d_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    always_comb
    begin
        if (nq_reg[DIV_STEPS][DIV_STEPS-1:QW] != '0)
            q_next = neg_reg[DIV_STEPS] ? Q_MIN : Q_MAX;
        else
            q_next = sat_mag(nq_reg[DIV_STEPS][QW-1:0], neg_reg[DIV_STEPS]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

@@ rtl/svpl_coef.sv @@
// Free-running pipeline that derives the offsets of segments one and two from the registers.
module svpl_coef (
    input  logic          clk,
    input  svpl_pkg::q_t  slope_z0,
    input  svpl_pkg::q_t  slope_z1,
    input  svpl_pkg::q_t  slope_z2,
    input  svpl_pkg::q_t  z_limit0,
    input  svpl_pkg::q_t  z_limit1,
    input  svpl_pkg::q_t  offset0,
    output svpl_pkg::q_t  offset1,
    output svpl_pkg::q_t  offset2
);
    import svpl_pkg::*;

    q_t d01_reg, d12_reg, lim0_reg, lim1_reg;
    q_t prod1, prod2;
    q_t c1_reg, c2_reg, p2_reg;

    always_ff @(posedge clk)
    begin
        d01_reg  <= sat_sub(slope_z0, slope_z1);
        d12_reg  <= sat_sub(slope_z1, slope_z2);
        lim0_reg <= z_limit0;
        lim1_reg <= z_limit1;
        c1_reg   <= sat_add(offset0, prod1);
        p2_reg   <= prod2;
        c2_reg   <= sat_add(c1_reg, p2_reg);
    end

    svpl_mul u_mul1 (.clk(clk), .en(1'b1), .a(d01_reg), .b(lim0_reg), .p(prod1));
    svpl_mul u_mul2 (.clk(clk), .en(1'b1), .a(d12_reg), .b(lim1_reg), .p(prod2));

    assign offset1 = c1_reg;
    assign offset2 = c2_reg;

endmodule

@@ rtl/segmented_v_plane_line_intersection.sv @@
// Top level of the segmented V-plane track intersection pipeline.
// The block intersects a straight track, given as a point and a direction in signed
// Q31.16, with a surface that is V-shaped in x and made of up to three plane segments
// along z, and returns the hit point, the segment and the wing that were used. It is a
// fully pipelined design: one beat is accepted on every clock cycle while in_stall is low.
// The depth of the pipeline is set by two chained 66-stage radix-2 dividers (the track
// slopes, then the per-segment hit z), joined by rounds of four-stage 48-bit multipliers.
// All segments and both wings are solved side by side and the first segment whose hit z
// lies below its limit is picked at the end. The whole pipeline moves as one: it holds
// only when a result sits in the output register and out_stall is high, which in turn
// raises in_stall. The joint offsets of segments one and two are recomputed by a small
// free-running pipeline after any register write, well ahead of any beat accepted later
// that needs them. A zero dir_z or a zero plane denominator on an evaluated wing raises
// divide_error with all other result fields at zero; every arithmetic step saturates.
module segmented_v_plane_line_intersection (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [svpl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  svpl_pkg::q_t                       cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  svpl_pkg::q_t                       point_x,
    input  svpl_pkg::q_t                       point_y,
    input  svpl_pkg::q_t                       point_z,
    input  svpl_pkg::q_t                       dir_x,
    input  svpl_pkg::q_t                       dir_y,
    input  svpl_pkg::q_t                       dir_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output svpl_pkg::q_t                       hit_x,
    output svpl_pkg::q_t                       hit_y,
    output svpl_pkg::q_t                       hit_z,
    output logic [svpl_pkg::SEG_W-1:0]         segment,
    output logic                               negative_wing,
    output logic                               divide_error
);
    import svpl_pkg::*;

    // Pipeline timeline, counted in advances after the accepting edge.
    localparam int T_B = DIV_LAT;             // bx and by leave the first dividers
    localparam int T_T = T_B + MUL_LAT;       // t, by*pz and sx*px ready
    localparam int T_M = T_T + MUL_LAT;       // t*pz ready
    localparam int T_D = T_M + 3;             // segment dividers are fed
    localparam int T_Z = T_D + DIV_LAT;       // hit z of every segment and wing
    localparam int T_X = T_Z + 1 + MUL_LAT;   // bx*(z-pz) ready
    localparam int T_S = T_X + 1;             // segment selection
    localparam int T_Y = T_S + 2 + MUL_LAT;   // by*(z-pz) ready

    localparam int DIR_LEN = T_S + 2 - T_B;
    localparam int ZF_LEN  = T_S - T_D;
    localparam int ZD_LEN  = T_S - T_Z;
    localparam int SEL_LEN = T_Y - T_S;

    // Configuration registers.
    q_t slope_x_reg, slope_z0_reg, slope_z1_reg, slope_z2_reg;
    q_t offset0_reg, z_limit0_reg, z_limit1_reg, z_limit2_reg;
    q_t offset1, offset2;
    q_t sz [3];
    q_t lim [3];
    q_t cst [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_x_reg  <= '0;
            slope_z0_reg <= '0;
            slope_z1_reg <= '0;
            slope_z2_reg <= '0;
            offset0_reg  <= '0;
            z_limit0_reg <= Z_LIMIT0_RST;
            z_limit1_reg <= Z_LIMIT1_RST;
            z_limit2_reg <= Z_LIMIT2_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SLOPE_X:  slope_x_reg  <= cfg_data;
                REG_SLOPE_Z0: slope_z0_reg <= cfg_data;
                REG_SLOPE_Z1: slope_z1_reg <= cfg_data;
                REG_SLOPE_Z2: slope_z2_reg <= cfg_data;
                REG_OFFSET0:  offset0_reg  <= cfg_data;
                REG_Z_LIMIT0: z_limit0_reg <= cfg_data;
                REG_Z_LIMIT1: z_limit1_reg <= cfg_data;
                REG_Z_LIMIT2: z_limit2_reg <= cfg_data;
            endcase
        end
    end

    svpl_coef u_coef (
        .clk      (clk),
        .slope_z0 (slope_z0_reg),
        .slope_z1 (slope_z1_reg),
        .slope_z2 (slope_z2_reg),
        .z_limit0 (z_limit0_reg),
        .z_limit1 (z_limit1_reg),
        .offset0  (offset0_reg),
        .offset1  (offset1),
        .offset2  (offset2)
    );

    assign sz[0]  = slope_z0_reg;
    assign sz[1]  = slope_z1_reg;
    assign sz[2]  = slope_z2_reg;
    assign lim[0] = z_limit0_reg;
    assign lim[1] = z_limit1_reg;
    assign lim[2] = z_limit2_reg;
    assign cst[0] = offset0_reg;
    assign cst[1] = offset1;
    assign cst[2] = offset2;

    // Global advance: the whole pipeline moves unless a held result is being stalled.
    logic adv;
    logic out_valid_reg;
    logic vld_reg [T_Y];

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < T_Y; j++)
                vld_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j < T_Y; j++)
                vld_reg[j] <= vld_reg[j-1];
            out_valid_reg <= vld_reg[T_Y-1];
        end
    end

    // Track point carried along the whole pipeline.
    trk_t trk_reg [T_Y];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trk_reg[0] <= '{px: point_x, py: point_y, pz: point_z, dzero: (dir_z == '0)};
            for (int j = 1; j < T_Y; j++)
                trk_reg[j] <= trk_reg[j-1];
        end
    end

    // Track slopes bx = dir_x/dir_z and by = dir_y/dir_z.
    q_t bx, by;

    svpl_div u_div_bx (.clk(clk), .en(adv), .a(dir_x), .b(dir_z), .q(bx));
    svpl_div u_div_by (.clk(clk), .en(adv), .a(dir_y), .b(dir_z), .q(by));

    dir_t dir_reg [DIR_LEN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dir_reg[0] <= '{bx: bx, by: by};
            for (int j = 1; j < DIR_LEN; j++)
                dir_reg[j] <= dir_reg[j-1];
        end
    end

    // First multiplier round: t = sx*bx, by*pz and sx*px.
    q_t t_v, bp, sp, tp;

    svpl_mul u_mul_t  (.clk(clk), .en(adv), .a(slope_x_reg), .b(bx), .p(t_v));
    svpl_mul u_mul_bp (.clk(clk), .en(adv), .a(by), .b(trk_reg[T_B-1].pz), .p(bp));
    svpl_mul u_mul_sp (.clk(clk), .en(adv), .a(slope_x_reg), .b(trk_reg[T_B-1].px), .p(sp));

    // Second round: t*pz.
    svpl_mul u_mul_tp (.clk(clk), .en(adv), .a(t_v), .b(trk_reg[T_T-1].pz), .p(tp));

    q_t t_reg  [MUL_LAT+1];
    q_t bp_reg [MUL_LAT];
    q_t sp_reg [MUL_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0]  <= t_v;
            bp_reg[0] <= bp;
            sp_reg[0] <= sp;
            for (int j = 1; j < MUL_LAT + 1; j++)
                t_reg[j] <= t_reg[j-1];
            for (int j = 1; j < MUL_LAT; j++)
            begin
                bp_reg[j] <= bp_reg[j-1];
                sp_reg[j] <= sp_reg[j-1];
            end
        end
    end

    // Three short stages form the numerators and denominators of every segment.
    q_t k_reg, m1_reg, m2_reg;
    q_t bs_reg   [NSEG];
    q_t base_reg [NSEG];
    q_t dp1_reg  [NSEG];
    q_t dn1_reg  [NSEG];
    q_t np_reg   [NSEG];
    q_t nn_reg   [NSEG];
    q_t dp2_reg  [NSEG];
    q_t dn2_reg  [NSEG];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg  <= sat_sub(bp_reg[MUL_LAT-1], trk_reg[T_M-1].py);
            m1_reg <= sat_sub(sp_reg[MUL_LAT-1], tp);
            m2_reg <= m1_reg;
            for (int i = 0; i < NSEG; i++)
            begin
                bs_reg[i]   <= sat_sub(dir_reg[T_M-T_B-1].by, sz[i]);
                base_reg[i] <= sat_add(k_reg, cst[i]);
                dp1_reg[i]  <= sat_sub(bs_reg[i], t_reg[MUL_LAT]);
                dn1_reg[i]  <= sat_add(bs_reg[i], t_reg[MUL_LAT]);
                np_reg[i]   <= sat_add(base_reg[i], m2_reg);
                nn_reg[i]   <= sat_sub(base_reg[i], m2_reg);
                dp2_reg[i]  <= dp1_reg[i];
                dn2_reg[i]  <= dn1_reg[i];
            end
        end
    end

    // Zero-denominator flags follow the segment dividers.
    logic [NSEG-1:0] zfp_reg [ZF_LEN];
    logic [NSEG-1:0] zfn_reg [ZF_LEN];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSEG; i++)
            begin
                zfp_reg[0][i] <= (dp2_reg[i] == '0);
                zfn_reg[0][i] <= (dn2_reg[i] == '0);
            end
            for (int j = 1; j < ZF_LEN; j++)
            begin
                zfp_reg[j] <= zfp_reg[j-1];
                zfn_reg[j] <= zfn_reg[j-1];
            end
        end
    end

    // Per segment and wing: hit z, then hit x.
    q_t zp      [NSEG];
    q_t zn      [NSEG];
    q_t xp_prod [NSEG];
    q_t xn_prod [NSEG];
    q_t dfp_reg [NSEG];
    q_t dfn_reg [NSEG];
    q_t xp_reg  [NSEG];
    q_t xn_reg  [NSEG];
    q_t zp_reg  [ZD_LEN][NSEG];
    q_t zn_reg  [ZD_LEN][NSEG];

    for (genvar i = 0; i < NSEG; i++)
    begin : g_seg
        svpl_div u_div_p (.clk(clk), .en(adv), .a(np_reg[i]), .b(dp2_reg[i]), .q(zp[i]));
        svpl_div u_div_n (.clk(clk), .en(adv), .a(nn_reg[i]), .b(dn2_reg[i]), .q(zn[i]));
        svpl_mul u_mul_p (
            .clk (clk), .en(adv), .a(dir_reg[T_Z-T_B].bx), .b(dfp_reg[i]), .p(xp_prod[i])
        );
        svpl_mul u_mul_n (
            .clk (clk), .en(adv), .a(dir_reg[T_Z-T_B].bx), .b(dfn_reg[i]), .p(xn_prod[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSEG; i++)
            begin
                dfp_reg[i]   <= sat_sub(zp[i], trk_reg[T_Z-1].pz);
                dfn_reg[i]   <= sat_sub(zn[i], trk_reg[T_Z-1].pz);
                xp_reg[i]    <= sat_add(trk_reg[T_X-1].px, xp_prod[i]);
                xn_reg[i]    <= sat_add(trk_reg[T_X-1].px, xn_prod[i]);
                zp_reg[0][i] <= zp[i];
                zn_reg[0][i] <= zn[i];
                for (int j = 1; j < ZD_LEN; j++)
                begin
                    zp_reg[j][i] <= zp_reg[j-1][i];
                    zn_reg[j][i] <= zn_reg[j-1][i];
                end
            end
        end
    end

    // Segment selection: first segment whose hit z is below its limit, else the last one.
    sel_t sel_next;
    q_t   selx_next;
    sel_t sel_reg [SEL_LEN];
    q_t   selx_reg [SEL_LEN];

    always_comb
    begin
        logic done;
        done      = 1'b0;
        sel_next  = '{z: '0, seg: '0, wing: 1'b0, err: trk_reg[T_S-1].dzero};
        selx_next = '0;
        if (!trk_reg[T_S-1].dzero)
        begin
            for (int i = 0; i < NSEG; i++)
            begin
                if (!done)
                begin
                    sel_next.seg  = SEG_W'(i);
                    sel_next.wing = 1'b0;
                    if (zfp_reg[ZF_LEN-1][i])
                    begin
                        sel_next.err = 1'b1;
                        done         = 1'b1;
                    end
                    else
                    begin
                        sel_next.z = zp_reg[ZD_LEN-1][i];
                        selx_next  = xp_reg[i];
                        if (xp_reg[i][QW-1])
                        begin
                            if (zfn_reg[ZF_LEN-1][i])
                            begin
                                sel_next.err = 1'b1;
                                done         = 1'b1;
                            end
                            else
                            begin
                                sel_next.z    = zn_reg[ZD_LEN-1][i];
                                selx_next     = xn_reg[i];
                                sel_next.wing = 1'b1;
                            end
                        end
                        if (!done && (sel_next.z < lim[i]))
                            done = 1'b1;
                    end
                end
            end
        end
    end

    q_t dy_reg, y_prod;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_reg[0]  <= sel_next;
            selx_reg[0] <= selx_next;
            for (int j = 1; j < SEL_LEN; j++)
            begin
                sel_reg[j]  <= sel_reg[j-1];
                selx_reg[j] <= selx_reg[j-1];
            end
            dy_reg <= sat_sub(sel_reg[0].z, trk_reg[T_S].pz);
        end
    end

    svpl_mul u_mul_y (.clk(clk), .en(adv), .a(dir_reg[DIR_LEN-1].by), .b(dy_reg), .p(y_prod));

    // Output register; an error beat carries zeros in every field but the flag.
    q_t               hit_x_reg, hit_y_reg, hit_z_reg;
    logic [SEG_W-1:0] segment_reg;
    logic             wing_reg, err_reg;
    sel_t             fin;

    assign fin = sel_reg[SEL_LEN-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err_reg <= fin.err;
            if (fin.err)
            begin
                hit_x_reg   <= '0;
                hit_y_reg   <= '0;
                hit_z_reg   <= '0;
                segment_reg <= '0;
                wing_reg    <= 1'b0;
            end
            else
            begin
                hit_x_reg   <= selx_reg[SEL_LEN-1];
                hit_y_reg   <= sat_add(trk_reg[T_Y-1].py, y_prod);
                hit_z_reg   <= fin.z;
                segment_reg <= fin.seg;
                wing_reg    <= fin.wing;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit_x         = hit_x_reg;
    assign hit_y         = hit_y_reg;
    assign hit_z         = hit_z_reg;
    assign segment       = segment_reg;
    assign negative_wing = wing_reg;
    assign divide_error  = err_reg;

endmodule
